// ----- hdl/ifbrm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ifbrm_pkg: shared types and constants of the flow byte-rate meter.
// Holds the channel item types, the controller states and the command and
// status groups that join the controller and the datapath.
// ---------------------------------------------------------------------------
package ifbrm_pkg;

   localparam int FLOWS_DEF          = 16;
   localparam int ADDRS_PER_FLOW_DEF = 16;

   localparam int          COUNT_W       = 48;
   localparam int          RATE_W        = 51;
   localparam int          RESULT_LIMIT  = 16;
   localparam logic [15:0] TYPE_VLAN     = 16'h8100;
   localparam logic [15:0] TYPE_IPV4     = 16'h0800;
   localparam logic [5:0]  POS_MAX       = 6'd63;

   localparam logic [1:0] ACT_BYTE = 2'd0;
   localparam logic [1:0] ACT_LOAD = 2'd1;
   localparam logic [1:0] ACT_TICK = 2'd2;

   localparam logic [1:0] CSR_ACTIVE_FLOWS = 2'd0;
   localparam logic [1:0] CSR_PERIOD       = 2'd1;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  data_byte;
      logic        byte_last;
      logic [15:0] packet_length;
      logic [3:0]  entry_flow;
      logic [3:0]  entry_slot;
      logic [31:0] entry_address;
      logic        entry_valid;
   } req_type;

   typedef struct packed {
      logic [3:0]        flow_index;
      logic [RATE_W-1:0] bits_per_second;
      logic              report_last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_ADD_WR,
      ST_RPT_RD,
      ST_RPT_LD,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic accept;
      logic srch_rd;
      logic cnt_rd;
      logic srch_next;
      logic add_wr;
      logic rpt_rd;
      logic rpt_load;
      logic div_step;
      logic rpt_next;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic frame_hit;
      logic tick_go;
      logic match;
      logic srch_last;
      logic div_done;
      logic rpt_last;
   } sts_type;

endpackage

// ----- hdl/ifbrm_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ifbrm_ctrl: controller of the flow byte-rate meter.
// Sequences the clearing pass, the table search, the counter update and the
// per-flow report with its divider.
// ---------------------------------------------------------------------------
module ifbrm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              rsp_stall,
   input  ifbrm_pkg::sts_type sts,
   output ifbrm_pkg::cmd_type cmd,
   output logic              rsp_valid
);
   import ifbrm_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && sts.frame_hit) state_in = ST_SRCH_RD;
            else if (req_valid && sts.tick_go) state_in = ST_RPT_RD;
         end
         ST_SRCH_RD: state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: begin
            if (sts.match) state_in = ST_ADD_WR;
            else if (sts.srch_last) state_in = ST_IDLE;
            else state_in = ST_SRCH_RD;
         end
         ST_ADD_WR: state_in = ST_IDLE;
         ST_RPT_RD: state_in = ST_RPT_LD;
         ST_RPT_LD: state_in = ST_DIV;
         ST_DIV: begin
            if (sts.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = sts.rpt_last ? ST_IDLE : ST_RPT_RD;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd       = '0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR:    cmd.clr_step = 1'b1;
         ST_IDLE:     cmd.accept = 1'b1;
         ST_SRCH_RD:  cmd.srch_rd = 1'b1;
         ST_SRCH_CMP: begin
            cmd.cnt_rd    = 1'b1;
            cmd.srch_next = !sts.match;
         end
         ST_ADD_WR:   cmd.add_wr = 1'b1;
         ST_RPT_RD:   cmd.rpt_rd = 1'b1;
         ST_RPT_LD:   cmd.rpt_load = 1'b1;
         ST_DIV:      cmd.div_step = 1'b1;
         ST_OUT: begin
            rsp_valid    = 1'b1;
            cmd.rpt_next = !rsp_stall;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ----- hdl/ifbrm_dpath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ifbrm_dpath: datapath of the flow byte-rate meter.
// Frame parser, address table and counter memories, search and report
// counters, and a restoring divider that retires one quotient bit a cycle.
// ---------------------------------------------------------------------------
module ifbrm_dpath #(
   parameter int FLOWS          = ifbrm_pkg::FLOWS_DEF,
   parameter int ADDRS_PER_FLOW = ifbrm_pkg::ADDRS_PER_FLOW_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  ifbrm_pkg::req_type req_data,
   input  logic               csr_valid,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  ifbrm_pkg::cmd_type cmd,
   output ifbrm_pkg::sts_type sts,
   output ifbrm_pkg::rsp_type rsp_data
);
   import ifbrm_pkg::*;

   localparam int FW      = (FLOWS > 1) ? $clog2(FLOWS) : 1;
   localparam int SW      = (ADDRS_PER_FLOW > 1) ? $clog2(ADDRS_PER_FLOW) : 1;
   localparam int AW      = FW + SW;
   localparam int RPT_MAX = (FLOWS < RESULT_LIMIT) ? FLOWS : RESULT_LIMIT;

   // Configuration registers.
   logic [4:0]  active_ff;
   logic [15:0] period_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 5'd0;
         period_ff <= 16'd1;
      end else if (csr_valid) begin
         if (csr_index == CSR_ACTIVE_FLOWS) active_ff <= csr_data[4:0];
         else if (csr_index == CSR_PERIOD) period_ff <= csr_data;
      end
   end

   logic req_fire;
   assign req_fire = cmd.accept && req_valid;

   // Frame parser.
   logic [5:0]  pos_ff, pos_in;
   logic [1:0]  vlan_ff, vlan_in;
   logic [15:0] type_ff, type_in;
   logic        ipv4_ff, ipv4_in;
   logic [31:0] dst_ff, dst_in;
   logic [5:0]  type_at, dst_at;
   logic [15:0] type_full;
   logic        byte_fire, count_go;

   assign byte_fire = req_fire && (req_data.action == ACT_BYTE);
   assign type_at   = 6'd12 + {2'b00, vlan_ff, 2'b00};
   assign dst_at    = 6'd30 + {2'b00, vlan_ff, 2'b00};
   assign type_full = {type_ff[7:0], req_data.data_byte};

   always_comb begin
      vlan_in = vlan_ff;
      type_in = type_ff;
      ipv4_in = ipv4_ff;
      dst_in  = dst_ff;
      if (pos_ff == type_at) begin
         type_in = {8'd0, req_data.data_byte};
      end else if (pos_ff == type_at + 6'd1) begin
         type_in = type_full;
         if (type_full == TYPE_VLAN && vlan_ff < 2'd2) vlan_in = vlan_ff + 2'd1;
         else ipv4_in = (type_full == TYPE_IPV4);
      end else if (ipv4_ff && pos_ff >= dst_at && pos_ff < dst_at + 6'd4) begin
         dst_in = {dst_ff[23:0], req_data.data_byte};
      end
      pos_in = (pos_ff < POS_MAX) ? pos_ff + 6'd1 : pos_ff;
   end

   assign count_go = byte_fire && req_data.byte_last && ipv4_ff &&
                     (pos_ff >= dst_at + 6'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         vlan_ff <= '0;
         type_ff <= '0;
         ipv4_ff <= 1'b0;
         dst_ff  <= '0;
      end else if (byte_fire) begin
         if (req_data.byte_last) begin
            pos_ff  <= '0;
            vlan_ff <= '0;
            type_ff <= '0;
            ipv4_ff <= 1'b0;
            dst_ff  <= '0;
         end else begin
            pos_ff  <= pos_in;
            vlan_ff <= vlan_in;
            type_ff <= type_in;
            ipv4_ff <= ipv4_in;
            dst_ff  <= dst_in;
         end
      end
   end

   // Search key and length, held while the table is scanned.
   logic [31:0] key_ff;
   logic [15:0] len_ff;
   always_ff @(posedge clock) begin
      if (count_go) begin
         key_ff <= dst_in;
         len_ff <= req_data.packet_length;
      end
   end

   // Clearing pass index.
   logic [AW-1:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr_step) clr_ff <= clr_ff + AW'(1);
   end
   assign sts.clr_done = (clr_ff == {AW{1'b1}});

   // Search position.
   logic [FW-1:0] sf_ff;
   logic [SW-1:0] ss_ff;
   logic          s_wrap;
   assign s_wrap = (ss_ff == SW'(ADDRS_PER_FLOW - 1));
   always_ff @(posedge clock) begin
      if (reset) begin
         sf_ff <= '0;
         ss_ff <= '0;
      end else if (count_go) begin
         sf_ff <= '0;
         ss_ff <= '0;
      end else if (cmd.srch_next) begin
         ss_ff <= s_wrap ? '0 : ss_ff + SW'(1);
         if (s_wrap) sf_ff <= sf_ff + FW'(1);
      end
   end
   assign sts.srch_last = s_wrap && (sf_ff == FW'(FLOWS - 1));
   assign sts.frame_hit = count_go;

   // Address table memory: valid bit over address.
   logic [32:0]   tbl_mem [2**AW];
   logic [32:0]   tbl_rd_ff;
   logic [6:0]    ef_ext, es_ext;
   logic          load_ok;
   logic          tbl_we;
   logic [AW-1:0] tbl_wa;
   logic [32:0]   tbl_wd;

   assign ef_ext  = 7'(req_data.entry_flow);
   assign es_ext  = 7'(req_data.entry_slot);
   assign load_ok = req_fire && (req_data.action == ACT_LOAD) &&
                    (ef_ext < 7'(FLOWS)) && (es_ext < 7'(ADDRS_PER_FLOW));

   always_comb begin
      tbl_we = cmd.clr_step || load_ok;
      tbl_wa = cmd.clr_step ? clr_ff : {ef_ext[FW-1:0], es_ext[SW-1:0]};
      tbl_wd = cmd.clr_step ? 33'd0 : {req_data.entry_valid, req_data.entry_address};
   end

   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
      if (cmd.srch_rd) tbl_rd_ff <= tbl_mem[{sf_ff, ss_ff}];
   end
   assign sts.match = tbl_rd_ff[32] && (tbl_rd_ff[31:0] == key_ff);

   // Report counters.
   logic [4:0] n_ff, i_ff, n_calc;
   logic [6:0] i_ext;
   assign n_calc = (active_ff > 5'(RPT_MAX)) ? 5'(RPT_MAX) : active_ff;
   assign sts.tick_go = (req_data.action == ACT_TICK) && (n_calc != 5'd0);
   assign i_ext = 7'(i_ff);
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
         i_ff <= '0;
      end else if (req_fire && req_data.action == ACT_TICK) begin
         n_ff <= n_calc;
         i_ff <= '0;
      end else if (cmd.rpt_next) begin
         i_ff <= i_ff + 5'd1;
      end
   end
   assign sts.rpt_last = (i_ff + 5'd1 == n_ff);

   // Byte counter memory.
   logic [COUNT_W-1:0] cnt_mem [2**FW];
   logic [COUNT_W-1:0] cnt_rd_ff;
   logic [COUNT_W:0]   cnt_sum;
   logic               cnt_we;
   logic [FW-1:0]      cnt_wa, cnt_ra;
   logic [COUNT_W-1:0] cnt_wd;

   assign cnt_sum = {1'b0, cnt_rd_ff} + (COUNT_W + 1)'(len_ff);
   always_comb begin
      cnt_we = cmd.clr_step || cmd.add_wr || cmd.rpt_load;
      cnt_ra = cmd.rpt_rd ? i_ext[FW-1:0] : sf_ff;
      if (cmd.clr_step) begin
         cnt_wa = clr_ff[FW-1:0];
         cnt_wd = '0;
      end else if (cmd.add_wr) begin
         cnt_wa = sf_ff;
         cnt_wd = cnt_sum[COUNT_W] ? {COUNT_W{1'b1}} : cnt_sum[COUNT_W-1:0];
      end else begin
         cnt_wa = i_ext[FW-1:0];
         cnt_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      if (cmd.cnt_rd || cmd.rpt_rd) cnt_rd_ff <= cnt_mem[cnt_ra];
   end

   // Restoring divider: quotient shifts in where the dividend shifts out.
   logic [RATE_W-1:0] quo_ff;
   logic [16:0]       rem_ff;
   logic [5:0]        dcnt_ff;
   logic [16:0]       rem_sh, divisor;
   logic              ge;

   assign divisor = (period_ff == 16'd0) ? 17'd1 : {1'b0, period_ff};
   assign rem_sh  = {rem_ff[15:0], quo_ff[RATE_W-1]};
   assign ge      = (rem_sh >= divisor);
   assign sts.div_done = (dcnt_ff == 6'(RATE_W - 1));

   always_ff @(posedge clock) begin
      if (cmd.rpt_load) begin
         quo_ff  <= {cnt_rd_ff, 3'b000};
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? rem_sh - divisor : rem_sh;
         quo_ff  <= {quo_ff[RATE_W-2:0], ge};
         dcnt_ff <= dcnt_ff + 6'd1;
      end
   end

   // Result item.
   assign rsp_data.flow_index      = i_ff[3:0];
   assign rsp_data.bits_per_second = quo_ff;
   assign rsp_data.report_last     = sts.rpt_last;

endmodule

// ----- hdl/ipv4_flow_byte_rate_meter_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipv4_flow_byte_rate_meter_unit: per-flow IPv4 byte counter and rate report.
// Top level joining the controller and the datapath.
// ---------------------------------------------------------------------------
// Usage:
// The req channel carries one item per frame byte, table load or report
// tick; an item is taken when req_valid is high and req_stall is low.
// A frame byte or a table load leaves the unit ready for the next item.
// The last byte of an IPv4 frame that carries a full destination starts a
// table scan that reads and compares each entry in turn until a match or
// the last entry, plus a counter update on a match; req_stall stays high
// meanwhile. A report tick gives one rsp item per active flow, up to
// FLOWS and at most 16. Each takes a counter read, a load and the divider
// steps, and is then held while rsp_stall is high.
// The csr port writes active_flows (index 0) and report_period_seconds
// (index 1); csr_ready is always high.
// After reset a clearing pass writes every table entry and counter to
// zero; no req item is taken then.
// ---------------------------------------------------------------------------
module ipv4_flow_byte_rate_meter_unit #(
   parameter int FLOWS          = ifbrm_pkg::FLOWS_DEF,
   parameter int ADDRS_PER_FLOW = ifbrm_pkg::ADDRS_PER_FLOW_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ifbrm_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ifbrm_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import ifbrm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;
   assign req_stall = !cmd.accept;

   // Controller.
   ifbrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   // Datapath.
   ifbrm_dpath #(
      .FLOWS          (FLOWS),
      .ADDRS_PER_FLOW (ADDRS_PER_FLOW)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hdl/ifbrm_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ifbrm_checker: port-level checks of the flow byte-rate meter.
// Watches the top level's channels and is bound to it below.
// ---------------------------------------------------------------------------
module ifbrm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input ifbrm_pkg::rsp_type rsp_data
);
   import ifbrm_pkg::*;

   // No result item is shown right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item shown after reset");

   // A stalled result item holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   // No request item is taken while a report is delivered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken during report");

   // Each delivered result is followed by a cycle without a result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("result items back to back");

endmodule

bind ipv4_flow_byte_rate_meter_unit ifbrm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
